// ===== rtl/core/trilinear_field_map_lookup_assert.svh =====
`ifndef TRILINEAR_FIELD_MAP_LOOKUP_ASSERT_SVH
`define TRILINEAR_FIELD_MAP_LOOKUP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TFML_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TFML_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tfml_pkg.sv =====
package tfml_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int FIELD_WIDTH = 24;
  localparam int FRAC_BITS   = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int DIM_W       = 12;
  localparam int POS_W       = 32;

  // Register reset values.
  localparam logic [31:0] INV_STEP_RST = 32'd65536;
  localparam logic [35:0] DIMS_RST     = 36'd268501008;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_X_ORIGIN   = 3'd0,
    CFG_Y_ORIGIN   = 3'd1,
    CFG_Z_ORIGIN   = 3'd2,
    CFG_X_INV_STEP = 3'd3,
    CFG_Y_INV_STEP = 3'd4,
    CFG_Z_INV_STEP = 3'd5,
    CFG_GRID_DIMS  = 3'd6
  } cfg_idx_t;

  // Request kinds.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE, ST_AXD, ST_AXM, ST_AXC, ST_IDX, ST_RD, ST_LERP, ST_OUT
  } state_t;

  typedef struct packed {
    logic                          req_type;
    logic [11:0]                   table_index;
    logic signed [POS_W-1:0]       pos_x;
    logic signed [POS_W-1:0]       pos_y;
    logic signed [POS_W-1:0]       pos_z;
    logic signed [FIELD_WIDTH-1:0] write_bx;
    logic signed [FIELD_WIDTH-1:0] write_by;
    logic signed [FIELD_WIDTH-1:0] write_bz;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] field_x;
    logic signed [FIELD_WIDTH-1:0] field_y;
    logic signed [FIELD_WIDTH-1:0] field_z;
    logic                          inside_res;
  } out_t;

  // One stored field vector.
  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] vx;
    logic signed [FIELD_WIDTH-1:0] vy;
    logic signed [FIELD_WIDTH-1:0] vz;
  } vec_t;

endpackage

// ===== rtl/core/trilinear_field_map_lookup.sv =====
// Write item: accepted, stored in the table, no result.
// Query item: when inside, the result follows the three axis conversions on the shared
// multiplier, the address products, the eight table reads through the single read port
// and the interpolation lerps; an outside result is given as soon as an axis conversion
// finds the position outside. The next item is taken in the cycle after the result.
// Reset (synchronous, rst_n low) sets state, counters and config; table is not cleared.
module trilinear_field_map_lookup (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tfml_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tfml_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [35:0]     cfg_data
);

`include "trilinear_field_map_lookup_assert.svh"

  localparam int FW = tfml_pkg::FIELD_WIDTH;
  localparam int FB = tfml_pkg::FRAC_BITS;
  localparam int DW = tfml_pkg::DIM_W;
  localparam int GW = 64 - (32 - FB);

  tfml_pkg::state_t state_r, state_nxt;

  logic signed [31:0] org_r [3];
  logic [31:0]        inv_r [3];
  logic [35:0]        dims_r;

  tfml_pkg::in_t      req_r;
  logic [1:0]         ax_r;
  logic [3:0]         cnt_r;
  logic signed [32:0] d_r;
  logic [GW-1:0]      g_r;
  logic [DW-1:0]      bin0_r [3];
  logic [DW-1:0]      bin1_r [3];
  logic [FB-1:0]      w_r [3];
  logic [23:0]        nxy_r;
  logic [23:0]        yo0_r, yo1_r;
  logic [35:0]        zo0_r, zo1_r;

  tfml_pkg::vec_t     field_mem [tfml_pkg::TABLE_DEPTH];
  tfml_pkg::vec_t     rd_q_r;
  logic               rd_oor_r;
  tfml_pkg::vec_t     corner_r [8];
  tfml_pkg::vec_t     s_r [6];
  tfml_pkg::out_t     out_r;

  logic               in_fire, out_fire;
  logic [DW-1:0]      n_sel;
  logic signed [31:0] pos_sel;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic               ax_out_m, ax_out_c;
  logic [DW-1:0]      n_m1;
  logic [DW-1:0]      bin0_c, bin1_c;
  logic [36:0]        rd_addr;
  tfml_pkg::vec_t     la, lb, lres;
  logic [FB-1:0]      lw;
  logic [DW-1:0]      nx, ny;

  // One component of a rounded-half-up linear blend.
  function automatic logic signed [FW-1:0] lerp1(
    input logic signed [FW-1:0] a,
    input logic signed [FW-1:0] b,
    input logic [FB-1:0]        w
  );
    logic signed [FW+FB+1:0] ae, be, wae, wbe, s;
    ae  = (FW+FB+2)'(a);
    be  = (FW+FB+2)'(b);
    wae = (FW+FB+2)'((FB+1)'(1 << FB) - (FB+1)'(w));
    wbe = (FW+FB+2)'(w);
    s   = ae * wae + be * wbe + (FW+FB+2)'(1 << (FB - 1));
    return s[FW+FB-1:FB];
  endfunction

  function automatic tfml_pkg::vec_t lerp3(
    input tfml_pkg::vec_t a,
    input tfml_pkg::vec_t b,
    input logic [FB-1:0]  w
  );
    tfml_pkg::vec_t r;
    r.vx = lerp1(a.vx, b.vx, w);
    r.vy = lerp1(a.vy, b.vy, w);
    r.vz = lerp1(a.vz, b.vz, w);
    return r;
  endfunction

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign cfg_ready = 1'b1;
  assign out_data  = out_r;
  assign nx        = dims_r[11:0];
  assign ny        = dims_r[23:12];

  // Per-axis operand selection.
  always_comb begin
    case (ax_r)
      2'd0:    begin pos_sel = req_r.pos_x; n_sel = dims_r[11:0];  end
      2'd1:    begin pos_sel = req_r.pos_y; n_sel = dims_r[23:12]; end
      default: begin pos_sel = req_r.pos_z; n_sel = dims_r[35:24]; end
    endcase
  end

  // Range checks and corner indexes for the current axis.
  assign n_m1     = n_sel - DW'(1);
  assign ax_out_m = d_r[32] || (n_sel == '0);
  assign ax_out_c = g_r > GW'({n_m1, FB'(0)});
  assign bin0_c   = g_r[FB+DW-1:FB];
  assign bin1_c   = (bin0_c >= n_m1) ? n_m1 : bin0_c + DW'(1);

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      tfml_pkg::ST_AXM: begin
        mul_a = d_r[31:0];
        mul_b = inv_r[ax_r];
      end
      tfml_pkg::ST_IDX: begin
        case (cnt_r)
          4'd0:    begin mul_a = 32'(nx);        mul_b = 32'(ny);    end
          4'd1:    begin mul_a = 32'(bin0_r[1]); mul_b = 32'(nx);    end
          4'd2:    begin mul_a = 32'(bin1_r[1]); mul_b = 32'(nx);    end
          4'd3:    begin mul_a = 32'(bin0_r[2]); mul_b = 32'(nxy_r); end
          default: begin mul_a = 32'(bin1_r[2]); mul_b = 32'(nxy_r); end
        endcase
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Corner address: z selects by bit 2, y by bit 1, x by bit 0.
  always_comb begin
    logic [35:0] zo;
    logic [23:0] yo;
    logic [DW-1:0] xo;
    zo = cnt_r[2] ? zo1_r : zo0_r;
    yo = cnt_r[1] ? yo1_r : yo0_r;
    xo = cnt_r[0] ? bin1_r[0] : bin0_r[0];
    rd_addr = 37'(zo) + 37'(yo) + 37'(xo);
  end

  // Interpolation operand selection: four x blends, two y blends, one z blend.
  always_comb begin
    case (cnt_r)
      4'd0:    begin la = corner_r[0]; lb = corner_r[1]; lw = w_r[0]; end
      4'd1:    begin la = corner_r[2]; lb = corner_r[3]; lw = w_r[0]; end
      4'd2:    begin la = corner_r[4]; lb = corner_r[5]; lw = w_r[0]; end
      4'd3:    begin la = corner_r[6]; lb = corner_r[7]; lw = w_r[0]; end
      4'd4:    begin la = s_r[0];      lb = s_r[1];      lw = w_r[1]; end
      4'd5:    begin la = s_r[2];      lb = s_r[3];      lw = w_r[1]; end
      default: begin la = s_r[4];      lb = s_r[5];      lw = w_r[2]; end
    endcase
  end

  assign lres = lerp3(la, lb, lw);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tfml_pkg::ST_IDLE:
        if (in_fire && in_data.req_type == tfml_pkg::REQ_QUERY) state_nxt = tfml_pkg::ST_AXD;
      tfml_pkg::ST_AXD:  state_nxt = tfml_pkg::ST_AXM;
      tfml_pkg::ST_AXM:  state_nxt = ax_out_m ? tfml_pkg::ST_OUT : tfml_pkg::ST_AXC;
      tfml_pkg::ST_AXC: begin
        if (ax_out_c)          state_nxt = tfml_pkg::ST_OUT;
        else if (ax_r == 2'd2) state_nxt = tfml_pkg::ST_IDX;
        else                   state_nxt = tfml_pkg::ST_AXD;
      end
      tfml_pkg::ST_IDX:  if (cnt_r == 4'd4) state_nxt = tfml_pkg::ST_RD;
      tfml_pkg::ST_RD:   if (cnt_r == 4'd8) state_nxt = tfml_pkg::ST_LERP;
      tfml_pkg::ST_LERP: if (cnt_r == 4'd6) state_nxt = tfml_pkg::ST_OUT;
      tfml_pkg::ST_OUT:  if (out_fire) state_nxt = tfml_pkg::ST_IDLE;
      default:           state_nxt = tfml_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = (state_r == tfml_pkg::ST_IDLE);
    out_valid = (state_r == tfml_pkg::ST_OUT);
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfml_pkg::ST_IDLE;
      ax_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) cnt_r <= '0;
      else                      cnt_r <= cnt_r + 4'd1;
      if (state_r == tfml_pkg::ST_IDLE)                   ax_r <= '0;
      else if (state_r == tfml_pkg::ST_AXC && !ax_out_c)  ax_r <= ax_r + 2'd1;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      inv_r[0] <= tfml_pkg::INV_STEP_RST;
      inv_r[1] <= tfml_pkg::INV_STEP_RST;
      inv_r[2] <= tfml_pkg::INV_STEP_RST;
      dims_r   <= tfml_pkg::DIMS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tfml_pkg::CFG_X_ORIGIN:   org_r[0] <= cfg_data[31:0];
        tfml_pkg::CFG_Y_ORIGIN:   org_r[1] <= cfg_data[31:0];
        tfml_pkg::CFG_Z_ORIGIN:   org_r[2] <= cfg_data[31:0];
        tfml_pkg::CFG_X_INV_STEP: inv_r[0] <= cfg_data[31:0];
        tfml_pkg::CFG_Y_INV_STEP: inv_r[1] <= cfg_data[31:0];
        tfml_pkg::CFG_Z_INV_STEP: inv_r[2] <= cfg_data[31:0];
        tfml_pkg::CFG_GRID_DIMS:  dims_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Field table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (in_fire && in_data.req_type == tfml_pkg::REQ_WRITE) begin
      field_mem[in_data.table_index[tfml_pkg::ADDR_W-1:0]] <=
        {in_data.write_bx, in_data.write_by, in_data.write_bz};
    end
    rd_q_r   <= field_mem[rd_addr[tfml_pkg::ADDR_W-1:0]];
    rd_oor_r <= |rd_addr[36:tfml_pkg::ADDR_W];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) req_r <= in_data;
    case (state_r)
      tfml_pkg::ST_AXD: d_r <= 33'(pos_sel) - 33'(org_r[ax_r]);
      tfml_pkg::ST_AXM: begin
        g_r <= mul_p[63:32-FB];
        if (ax_out_m) out_r <= '0;
      end
      tfml_pkg::ST_AXC: begin
        bin0_r[ax_r] <= bin0_c;
        bin1_r[ax_r] <= bin1_c;
        w_r[ax_r]    <= g_r[FB-1:0];
        if (ax_out_c) out_r <= '0;
      end
      tfml_pkg::ST_IDX: begin
        case (cnt_r)
          4'd0:    nxy_r <= mul_p[23:0];
          4'd1:    yo0_r <= mul_p[23:0];
          4'd2:    yo1_r <= mul_p[23:0];
          4'd3:    zo0_r <= mul_p[35:0];
          default: zo1_r <= mul_p[35:0];
        endcase
      end
      tfml_pkg::ST_RD: begin
        if (cnt_r != 4'd0) corner_r[3'(cnt_r - 4'd1)] <= rd_oor_r ? '0 : rd_q_r;
      end
      tfml_pkg::ST_LERP: begin
        if (cnt_r == 4'd6) begin
          out_r.field_x    <= lres.vx;
          out_r.field_y    <= lres.vy;
          out_r.field_z    <= lres.vz;
          out_r.inside_res <= 1'b1;
        end else begin
          s_r[3'(cnt_r)] <= lres;
        end
      end
      default: ;
    endcase
  end

  // A pending result blocks new items.
  `TFML_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input ready while result pending")
  // A query starts the axis conversion at once.
  `TFML_ASSERT_NEXT(a_query_start, clk, rst_n, in_fire && in_data.req_type == tfml_pkg::REQ_QUERY, state_r == tfml_pkg::ST_AXD, "query did not start")
  // A write gives no result and frees the block.
  `TFML_ASSERT_NEXT(a_write_done, clk, rst_n, in_fire && in_data.req_type == tfml_pkg::REQ_WRITE, in_ready && !out_valid, "write left block busy")
  // An outside result carries a zero vector.
  `TFML_ASSERT_NOW(a_outside_zero, clk, rst_n, out_valid && !out_data.inside_res, out_data.field_x == '0 && out_data.field_y == '0 && out_data.field_z == '0, "outside result not zero")

endmodule
